@@ design/gl_pkg.sv @@
// ----------------------------------------------------------------------------
// gl_pkg
// Shared types, codes and default sizes of the graph Laplacian builder.
// ----------------------------------------------------------------------------
package gl_pkg;

  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_ENTRY_BITS   = 16;

  localparam int CMD_W    = 2;
  localparam int VTX_W    = 6;
  localparam int VCOUNT_W = 7;
  localparam int OUT_W    = 16;
  localparam int STATUS_W = 2;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(64);

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_VTX = 2'd1,
    STAT_ERROR   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CTRL_CLEAR,
    CTRL_IDLE,
    CTRL_EDGE_RD,
    CTRL_EDGE_WR,
    CTRL_READ_RD,
    CTRL_READ_DATA,
    CTRL_RESULT
  } ctrl_state_e;

endpackage

@@ design/gl_req_if.sv @@
// ----------------------------------------------------------------------------
// gl_req_if
// Request channel: command and two vertex indices.
// ----------------------------------------------------------------------------
interface gl_req_if import gl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [VTX_W-1:0] first_vertex;
  logic [VTX_W-1:0] second_vertex;

  modport source (output valid, command, first_vertex, second_vertex, input ready);
  modport sink   (input valid, command, first_vertex, second_vertex, output ready);
endinterface

@@ design/gl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// gl_rsp_if
// Response channel: entry read and status.
// ----------------------------------------------------------------------------
interface gl_rsp_if import gl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_W-1:0]    entry_value;
  logic        [STATUS_W-1:0] status;

  modport source (output valid, entry_value, status, input ready);
  modport sink   (input valid, entry_value, status, output ready);
endinterface

@@ design/gl_cfg_if.sv @@
// ----------------------------------------------------------------------------
// gl_cfg_if
// Configuration write channel for the vertex count register.
// ----------------------------------------------------------------------------
interface gl_cfg_if import gl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VCOUNT_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ design/gl_store.sv @@
// ----------------------------------------------------------------------------
// gl_store
// Single-port matrix store with registered read data.
// ----------------------------------------------------------------------------
module gl_store import gl_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_VERTICES * DEF_MAX_VERTICES,
  parameter int DATA_W = DEF_ENTRY_BITS,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic        [ADDR_W-1:0] addr_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/gl_sat.sv @@
// ----------------------------------------------------------------------------
// gl_sat
// Shared saturating increment / decrement unit for entry updates.
// ----------------------------------------------------------------------------
module gl_sat import gl_pkg::*; #(
  parameter int ENTRY_BITS = DEF_ENTRY_BITS
) (
  input  logic signed [ENTRY_BITS-1:0] operand_i,
  input  logic                         inc_i,
  output logic signed [ENTRY_BITS-1:0] result_o
);

  localparam logic signed [ENTRY_BITS-1:0] EntryMax = {1'b0, {(ENTRY_BITS-1){1'b1}}};
  localparam logic signed [ENTRY_BITS-1:0] EntryMin = {1'b1, {(ENTRY_BITS-1){1'b0}}};
  localparam logic signed [ENTRY_BITS-1:0] One      = ENTRY_BITS'(1);

  always_comb begin
    if (inc_i) begin
      result_o = (operand_i == EntryMax) ? operand_i : operand_i + One;
    end else begin
      result_o = (operand_i == EntryMin) ? operand_i : operand_i - One;
    end
  end

endmodule

@@ design/gl_ctrl.sv @@
// ----------------------------------------------------------------------------
// gl_ctrl
// Sequencer: clear sweeps, four read-modify-write updates per edge,
// entry reads, and the response register.
// ----------------------------------------------------------------------------
module gl_ctrl import gl_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int ENTRY_BITS   = DEF_ENTRY_BITS,
  localparam int DEPTH  = MAX_VERTICES * MAX_VERTICES,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic        [VCOUNT_W-1:0]   vertex_count_i,
  gl_req_if.sink                       req_i,
  gl_rsp_if.source                     rsp_o,
  output logic                         mem_we_o,
  output logic        [ADDR_W-1:0]     mem_addr_o,
  output logic signed [ENTRY_BITS-1:0] mem_wdata_o,
  input  logic signed [ENTRY_BITS-1:0] mem_rdata_i,
  output logic signed [ENTRY_BITS-1:0] sat_operand_o,
  output logic                         sat_inc_o,
  input  logic signed [ENTRY_BITS-1:0] sat_result_i
);

  localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] RowStep  = ADDR_W'(MAX_VERTICES);
  localparam logic [31:0]       MaxVtx   = 32'(MAX_VERTICES);

  ctrl_state_e          state_q, state_d;
  logic [ADDR_W-1:0]    cnt_q, cnt_d;
  logic [1:0]           upd_q, upd_d;
  logic [VTX_W-1:0]     u_q, u_d, v_q, v_d;
  logic                 clr_rsp_q, clr_rsp_d;
  logic                 err_q, err_d;
  logic [OUT_W-1:0]     res_entry_q, res_entry_d;
  status_e              res_status_q, res_status_d;
  logic                 rsp_valid_q, rsp_valid_d;
  logic [OUT_W-1:0]     rsp_entry_q, rsp_entry_d;
  status_e              rsp_status_q, rsp_status_d;

  logic                 accept;
  logic                 slot_free;
  logic                 in_range;
  cmd_e                 cmd;
  logic [VTX_W-1:0]     row, col;
  logic [ADDR_W-1:0]    upd_addr;
  logic signed [31:0]   rd_ext;

  assign cmd       = cmd_e'(req_i.command);
  assign accept    = req_i.valid && (state_q == CTRL_IDLE);
  assign slot_free = !rsp_valid_q || rsp_o.ready;
  assign in_range  = (VCOUNT_W'(req_i.first_vertex) < vertex_count_i)
                  && (VCOUNT_W'(req_i.second_vertex) < vertex_count_i)
                  && (32'(req_i.first_vertex) < MaxVtx)
                  && (32'(req_i.second_vertex) < MaxVtx);

  // update order: (u,u)+1, (v,v)+1, (u,v)-1, (v,u)-1
  assign row      = (upd_q == 2'd0 || upd_q == 2'd2) ? u_q : v_q;
  assign col      = (upd_q == 2'd0 || upd_q == 2'd3) ? u_q : v_q;
  assign upd_addr = ADDR_W'(row) * RowStep + ADDR_W'(col);
  assign rd_ext   = 32'(mem_rdata_i);

  assign sat_operand_o = mem_rdata_i;
  assign sat_inc_o     = !upd_q[1];

  assign req_i.ready       = (state_q == CTRL_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.entry_value = rsp_entry_q;
  assign rsp_o.status      = rsp_status_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTRL_CLEAR: begin
        if (cnt_q == LastAddr) begin
          state_d = clr_rsp_q ? CTRL_RESULT : CTRL_IDLE;
        end
      end
      CTRL_IDLE: begin
        if (req_i.valid) begin
          unique case (cmd)
            CMD_START: state_d = CTRL_CLEAR;
            CMD_EDGE: begin
              if (err_q || !in_range || req_i.first_vertex == req_i.second_vertex) begin
                state_d = CTRL_RESULT;
              end else begin
                state_d = CTRL_EDGE_RD;
              end
            end
            CMD_READ: state_d = (err_q || !in_range) ? CTRL_RESULT : CTRL_READ_RD;
            default:  state_d = CTRL_RESULT;
          endcase
        end
      end
      CTRL_EDGE_RD:   state_d = CTRL_EDGE_WR;
      CTRL_EDGE_WR:   state_d = (upd_q == 2'd3) ? CTRL_RESULT : CTRL_EDGE_RD;
      CTRL_READ_RD:   state_d = CTRL_READ_DATA;
      CTRL_READ_DATA: state_d = CTRL_RESULT;
      CTRL_RESULT:    state_d = slot_free ? CTRL_IDLE : CTRL_RESULT;
      default:        state_d = CTRL_IDLE;
    endcase
  end

  always_comb begin
    cnt_d        = cnt_q;
    upd_d        = upd_q;
    u_d          = u_q;
    v_d          = v_q;
    clr_rsp_d    = clr_rsp_q;
    err_d        = err_q;
    res_entry_d  = res_entry_q;
    res_status_d = res_status_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_entry_d  = rsp_entry_q;
    rsp_status_d = rsp_status_q;
    mem_we_o     = 1'b0;
    mem_addr_o   = upd_addr;
    mem_wdata_o  = sat_result_i;

    unique case (state_q)
      CTRL_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = cnt_q;
        mem_wdata_o = '0;
        cnt_d       = cnt_q + ADDR_W'(1);
        if (cnt_q == LastAddr) begin
          clr_rsp_d = 1'b0;
        end
      end
      CTRL_IDLE: begin
        if (accept) begin
          u_d          = req_i.first_vertex;
          v_d          = req_i.second_vertex;
          upd_d        = 2'd0;
          res_entry_d  = '0;
          res_status_d = STAT_OK;
          unique case (cmd)
            CMD_START: begin
              cnt_d     = '0;
              clr_rsp_d = 1'b1;
              err_d     = 1'b0;
            end
            CMD_EDGE: begin
              if (err_q) begin
                res_status_d = STAT_ERROR;
              end else if (!in_range) begin
                res_status_d = STAT_BAD_VTX;
                err_d        = 1'b1;
              end
            end
            CMD_READ: begin
              // row u, column v shares the address path of the third update
              upd_d = 2'd2;
              if (err_q) begin
                res_status_d = STAT_ERROR;
              end else if (!in_range) begin
                res_status_d = STAT_BAD_VTX;
              end
            end
            default: begin
              res_status_d = err_q ? STAT_ERROR : STAT_OK;
            end
          endcase
        end
      end
      CTRL_EDGE_RD: begin
      end
      CTRL_EDGE_WR: begin
        mem_we_o = 1'b1;
        upd_d    = upd_q + 2'd1;
      end
      CTRL_READ_RD: begin
      end
      CTRL_READ_DATA: begin
        res_entry_d = rd_ext[OUT_W-1:0];
      end
      CTRL_RESULT: begin
        if (slot_free) begin
          rsp_valid_d  = 1'b1;
          rsp_entry_d  = res_entry_q;
          rsp_status_d = res_status_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CTRL_CLEAR;
      cnt_q       <= '0;
      clr_rsp_q   <= 1'b0;
      err_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_rsp_q   <= clr_rsp_d;
      err_q       <= err_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    upd_q        <= upd_d;
    u_q          <= u_d;
    v_q          <= v_d;
    res_entry_q  <= res_entry_d;
    res_status_q <= res_status_d;
    rsp_entry_q  <= rsp_entry_d;
    rsp_status_q <= rsp_status_d;
  end

endmodule

@@ design/graph_laplacian_builder.sv @@
// ----------------------------------------------------------------------------
// graph_laplacian_builder
// Builds the Laplacian of an undirected multigraph in a saturating store.
//
//   channel  dir  handshake     payload
//   cfg_i    in   valid/ready   data: vertex_count (7b)
//   req_i    in   valid/ready   command, first_vertex, second_vertex
//   rsp_o    out  valid/ready   entry_value (16b signed), status
//
// Edge request: four read/write pairs on the single store port.
// Read request: one store read; rejected or no-op request: straight to the result.
// Start request: clears all MAX_VERTICES*MAX_VERTICES store entries, one a cycle.
// After reset the same clearing sweep runs with req_i.ready low; cfg_i is
// always ready. A stalled rsp_o holds the result.
// ----------------------------------------------------------------------------
module graph_laplacian_builder import gl_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int ENTRY_BITS   = DEF_ENTRY_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  gl_cfg_if.sink   cfg_i,
  gl_req_if.sink   req_i,
  gl_rsp_if.source rsp_o
);

  localparam int DEPTH  = MAX_VERTICES * MAX_VERTICES;
  localparam int ADDR_W = $clog2(DEPTH);

  logic [VCOUNT_W-1:0]         vcount_q;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_addr;
  logic signed [ENTRY_BITS-1:0] mem_wdata, mem_rdata;
  logic signed [ENTRY_BITS-1:0] sat_operand, sat_result;
  logic                        sat_inc;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (cfg_i.valid) begin
      vcount_q <= cfg_i.data;
    end
  end

  gl_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .ENTRY_BITS   (ENTRY_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vertex_count_i (vcount_q),
    .req_i          (req_i),
    .rsp_o          (rsp_o),
    .mem_we_o       (mem_we),
    .mem_addr_o     (mem_addr),
    .mem_wdata_o    (mem_wdata),
    .mem_rdata_i    (mem_rdata),
    .sat_operand_o  (sat_operand),
    .sat_inc_o      (sat_inc),
    .sat_result_i   (sat_result)
  );

  gl_store #(
    .DEPTH  (DEPTH),
    .DATA_W (ENTRY_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  gl_sat #(
    .ENTRY_BITS (ENTRY_BITS)
  ) u_sat (
    .operand_i (sat_operand),
    .inc_i     (sat_inc),
    .result_o  (sat_result)
  );

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for graph_laplacian_builder. A clocked driver feeds
// requests and vertex-count writes from a backlog; a clocked monitor checks
// every response against an in-bench Laplacian model with saturating entries.
// Covers directed corner cases, random graphs under several vertex counts
// with varying back-pressure, and a run of one edge repeated many times.
// ----------------------------------------------------------------------------
module tb;
  import gl_pkg::*;

  localparam int NV             = DEF_MAX_VERTICES;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_RSP    = 150;
  localparam int REPEAT_EDGES   = 20;
  localparam int MAX_PRINTS     = 40;

  typedef struct {
    bit                  is_cfg;
    cmd_e                cmd;
    logic [VTX_W-1:0]    u;
    logic [VTX_W-1:0]    v;
    logic [VCOUNT_W-1:0] vcount;
    int                  send_idle;
    int                  recv_idle;
  } gl_item_t;

  typedef struct {
    logic signed [OUT_W-1:0] entry;
    status_e                 status;
  } gl_rsp_t;

  logic clk;
  logic rst_n;

  gl_req_if req_if ();
  gl_rsp_if rsp_if ();
  gl_cfg_if cfg_if ();

  graph_laplacian_builder u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  gl_item_t req_backlog[$];
  gl_rsp_t  due_rsp[$];

  logic signed [OUT_W-1:0] lap_store [NV][NV];
  bit                      err_flag;
  logic [VCOUNT_W-1:0]     vcount_q;

  int send_idle;
  int recv_idle;
  int req_count;
  int rsp_count;
  int mismatches;
  int hold_left;
  bit hold_done;
  int idle_cycles;
  int n_edges, n_reads, n_starts, n_nops, n_settings;
  int n_ok, n_bad, n_err;

  bit gen_in_error;
  int err_tail;

  function automatic void clear_store();
    for (int r = 0; r < NV; r++) begin
      for (int c = 0; c < NV; c++) begin
        lap_store[r][c] = '0;
      end
    end
  endfunction

  function automatic void bump_entry(int row, int col, int delta);
    int s;
    s = int'(lap_store[row][col]) + delta;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    lap_store[row][col] = s[OUT_W-1:0];
  endfunction

  function automatic gl_rsp_t laplacian_step(gl_item_t it);
    gl_rsp_t r;
    int n;
    n = (vcount_q > NV) ? NV : int'(vcount_q);
    r.entry = '0;
    r.status = STAT_OK;
    case (it.cmd)
      CMD_START: begin
        clear_store();
        err_flag = 1'b0;
      end
      CMD_EDGE: begin
        if (err_flag) begin
          r.status = STAT_ERROR;
        end else if (it.u >= n || it.v >= n) begin
          err_flag = 1'b1;
          r.status = STAT_BAD_VTX;
        end else if (it.u != it.v) begin
          bump_entry(it.u, it.u, 1);
          bump_entry(it.v, it.v, 1);
          bump_entry(it.u, it.v, -1);
          bump_entry(it.v, it.u, -1);
        end
      end
      CMD_READ: begin
        if (err_flag) r.status = STAT_ERROR;
        else if (it.u >= n || it.v >= n) r.status = STAT_BAD_VTX;
        else r.entry = lap_store[it.u][it.v];
      end
      default: r.status = err_flag ? STAT_ERROR : STAT_OK;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic gl_item_t mk_req(cmd_e cmd, int u, int v);
    gl_item_t it;
    it.is_cfg = 1'b0;
    it.cmd = cmd;
    it.u = u[VTX_W-1:0];
    it.v = v[VTX_W-1:0];
    it.vcount = '0;
    it.send_idle = 0;
    it.recv_idle = 0;
    return it;
  endfunction

  task automatic add_req(cmd_e cmd, int u, int v);
    req_backlog.insert(req_backlog.size(), mk_req(cmd, u, v));
  endtask

  task automatic add_setting(int vc, int si, int ri);
    gl_item_t it;
    it = mk_req(CMD_NOP, 0, 0);
    it.is_cfg = 1'b1;
    it.vcount = vc[VCOUNT_W-1:0];
    it.send_idle = si;
    it.recv_idle = ri;
    req_backlog.insert(req_backlog.size(), it);
  endtask

  task automatic add_random_graph(int count, int vc);
    int n, pick, a, b;
    n = (vc > NV) ? NV : vc;
    repeat (count) begin
      pick = $urandom_range(99);
      a = $urandom_range(63);
      b = $urandom_range(63);
      if (gen_in_error && err_tail == 0) begin
        add_req(CMD_START, a, b);
        gen_in_error = 1'b0;
      end else begin
        if (gen_in_error) err_tail--;
        if (pick < 3 && n < NV && !gen_in_error) begin
          if ($urandom_range(1)) a = $urandom_range(63, n);
          else b = $urandom_range(63, n);
          add_req(CMD_EDGE, a, b);
          gen_in_error = 1'b1;
          err_tail = $urandom_range(4);
        end else if (pick < 6) begin
          add_req(CMD_NOP, a, b);
        end else if (pick < 7) begin
          add_req(CMD_START, a, b);
          gen_in_error = 1'b0;
        end else if (pick < 10 && n < NV) begin
          if ($urandom_range(1)) a = $urandom_range(63, n);
          else b = $urandom_range(63, n);
          add_req(CMD_READ, a, b);
        end else if (n > 0) begin
          a = $urandom_range(n - 1);
          b = $urandom_range(n - 1);
          add_req(pick < 60 ? CMD_EDGE : CMD_READ, a, b);
        end else begin
          add_req(CMD_READ, a, b);
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // driver: one request or register write at a time, from the backlog head
  always @(posedge clk) begin
    bit       req_nx;
    bit       cfg_nx;
    gl_item_t it;
    gl_rsp_t  r;
    if (rst_n) begin
      req_nx = 1'b0;
      cfg_nx = 1'b0;
      if (req_if.valid && req_if.ready) begin
        it = req_backlog.pop_front();
        r = laplacian_step(it);
        due_rsp.insert(due_rsp.size(), r);
        req_count++;
        case (it.cmd)
          CMD_START: n_starts++;
          CMD_EDGE:  n_edges++;
          CMD_READ:  n_reads++;
          default:   n_nops++;
        endcase
      end else if (cfg_if.valid && cfg_if.ready) begin
        it = req_backlog.pop_front();
        vcount_q = it.vcount;
        send_idle = it.send_idle;
        recv_idle <= it.recv_idle;
        n_settings++;
      end
      if (req_if.valid && !req_if.ready) begin
        req_nx = 1'b1;
      end else if (cfg_if.valid && !cfg_if.ready) begin
        cfg_nx = 1'b1;
      end else if (req_backlog.size() > 0) begin
        it = req_backlog[0];
        if (it.is_cfg) begin
          // write only once every response is back
          if (req_count == rsp_count) begin
            cfg_nx = 1'b1;
            cfg_if.data <= it.vcount;
          end
        end else if ($urandom_range(99) >= send_idle) begin
          req_nx = 1'b1;
          req_if.command <= it.cmd;
          req_if.first_vertex <= it.u;
          req_if.second_vertex <= it.v;
        end
      end
      req_if.valid <= req_nx;
      cfg_if.valid <= cfg_nx;
    end
  end

  // monitor: check each response, then pick the next ready
  always @(posedge clk) begin
    gl_rsp_t want;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        rsp_count <= rsp_count + 1;
        case (rsp_if.status)
          STAT_OK:      n_ok++;
          STAT_BAD_VTX: n_bad++;
          default:      n_err++;
        endcase
        if (due_rsp.size() == 0) begin
          report_mismatch("unexpected response status", int'(rsp_if.status), -1);
        end else begin
          want = due_rsp.pop_front();
          if (rsp_if.entry_value !== want.entry)
            report_mismatch("entry_value", int'(rsp_if.entry_value), int'(want.entry));
          if (rsp_if.status !== want.status)
            report_mismatch("status", int'(rsp_if.status), int'(want.status));
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && rsp_count >= HOLD_AT_RSP) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
        (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $time, idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.command = CMD_NOP;
    req_if.first_vertex = '0;
    req_if.second_vertex = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    clear_store();
    err_flag = 1'b0;
    vcount_q = VCOUNT_RESET;
    send_idle = 0;
    recv_idle = 0;
    req_count = 0;
    rsp_count = 0;
    mismatches = 0;
    hold_left = 0;
    hold_done = 1'b0;
    idle_cycles = 0;
    gen_in_error = 1'b0;
    err_tail = 0;

    add_setting(5, 12, 54);
    add_req(CMD_READ, 0, 0);
    add_req(CMD_EDGE, 0, 1);
    add_req(CMD_EDGE, 1, 0);
    add_req(CMD_EDGE, 4, 3);
    add_req(CMD_EDGE, 2, 2);
    add_req(CMD_READ, 0, 0);
    add_req(CMD_READ, 0, 1);
    add_req(CMD_READ, 1, 0);
    add_req(CMD_READ, 4, 4);
    add_req(CMD_READ, 3, 4);
    add_req(CMD_READ, 2, 2);
    add_req(CMD_READ, 5, 0);
    add_req(CMD_READ, 0, 63);
    add_req(CMD_NOP, 63, 63);
    add_req(CMD_EDGE, 0, 4);
    add_req(CMD_READ, 4, 0);
    add_req(CMD_EDGE, 63, 0);
    add_req(CMD_EDGE, 1, 2);
    add_req(CMD_READ, 0, 0);
    add_req(CMD_NOP, 0, 0);
    add_req(CMD_START, 0, 0);
    add_req(CMD_READ, 0, 1);
    add_req(CMD_EDGE, 4, 0);
    add_req(CMD_READ, 0, 0);

    add_setting(64, 12, 54);
    add_random_graph(400, 64);
    add_setting(0, 12, 54);
    add_random_graph(20, 0);
    add_setting(127, 12, 54);
    add_random_graph(250, 127);

    add_setting(1, 54, 12);
    add_random_graph(30, 1);
    add_setting(2, 54, 12);
    add_random_graph(200, 2);
    add_setting(33, 54, 12);
    add_random_graph(400, 33);

    add_setting(64, 0, 0);
    add_random_graph(300, 64);
    add_setting(9, 0, 0);
    add_random_graph(300, 9);

    // build up one multi-edge between a single vertex pair
    add_setting(2, 0, 0);
    add_req(CMD_START, 0, 0);
    repeat (REPEAT_EDGES) add_req(CMD_EDGE, 0, 1);
    add_req(CMD_EDGE, 1, 0);
    add_req(CMD_READ, 0, 0);
    add_req(CMD_READ, 0, 1);
    add_req(CMD_READ, 1, 0);
    add_req(CMD_READ, 1, 1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || due_rsp.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("Covered %0d requests: %0d edges, %0d reads, %0d starts, %0d no-ops, %0d settings",
             req_count, n_edges, n_reads, n_starts, n_nops, n_settings);
    $display("Responses ok/bad-vertex/error-state: %0d/%0d/%0d, repeated-edge run included",
             n_ok, n_bad, n_err);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
